// File: rtl/tgapsd_pkg.sv
package tgapsd_pkg;

    // image types
    localparam logic [7:0] IMG_RAW_COLOR = 8'd2;
    localparam logic [7:0] IMG_GREY      = 8'd3;
    localparam logic [7:0] IMG_RLE_COLOR = 8'd10;

    // bits per pixel
    localparam logic [7:0] BPP_16 = 8'd16;
    localparam logic [7:0] BPP_24 = 8'd24;
    localparam logic [7:0] BPP_32 = 8'd32;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_TYPE  = 2'd0;
    localparam logic [1:0] CFG_COLOR_BITS  = 2'd1;
    localparam logic [1:0] CFG_PIXEL_COUNT = 2'd2;

    localparam int unsigned CFG_DATA_W    = 25;
    localparam int unsigned QUEUE_DEPTH   = 4;

    // rle packet header
    localparam logic [7:0] RLE_RUN_FLAG = 8'h80;
    localparam logic [7:0] RLE_RUN_BIAS = 8'd127;

    // pixel size codes (bytes per pixel minus one)
    localparam logic [1:0] SIZE_1B = 2'd0;
    localparam logic [1:0] SIZE_2B = 2'd1;
    localparam logic [1:0] SIZE_3B = 2'd2;
    localparam logic [1:0] SIZE_4B = 2'd3;

    localparam logic [4:0] RGB555_MASK = 5'h1F;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } tga_in_t;

    typedef struct packed {
        logic [31:0] pixel_argb;
        logic [7:0]  repeat_count;
        logic        image_last;
        logic        overrun_error;
    } tga_out_t;

    // decoded pixel handed from front to back
    typedef struct packed {
        logic [31:0] colour_accum;
        logic [1:0]  size_code;
        logic [7:0]  repeat_count;
        logic        image_last;
        logic        overrun_error;
    } tga_job_t;

    // queue status seen by the top and the back
    typedef struct packed {
        logic full;
        logic empty;
    } tga_queue_status_t;

endpackage

// File: rtl/tgapsd_front.sv
module tgapsd_front #(
    parameter int unsigned COUNT_BITS = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [1:0]                           cfg_index,
    input  logic [tgapsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 in_accept,
    input  tgapsd_pkg::tga_in_t                  in_item,
    output logic                                 push,
    output tgapsd_pkg::tga_job_t                 job
);

    localparam int unsigned CMP_W = (COUNT_BITS > 9) ? COUNT_BITS : 9;

    logic [7:0]            image_type_reg;
    logic [7:0]            color_bits_reg;
    logic [COUNT_BITS-1:0] pixel_count_reg;

    logic [COUNT_BITS-1:0] pixels_done_reg, pixels_done_next;
    logic [7:0]            packet_left_reg, packet_left_next;
    logic                  packet_is_run_reg, packet_is_run_next;
    logic [1:0]            byte_phase_reg, byte_phase_next;
    logic [31:0]           colour_accum_reg, colour_accum_next;
    logic                  clip_pending_reg, clip_pending_next;
    logic                  image_done_reg, image_done_next;

    // state as seen by this item, after an image start clears it
    logic [COUNT_BITS-1:0] pd_eff;
    logic [7:0]            pl_eff;
    logic                  run_eff;
    logic [1:0]            phase_eff;
    logic [31:0]           accum_eff;
    logic                  clip_eff;
    logic                  done_eff;

    logic                  mode_ok;
    logic                  coded;
    logic [1:0]            size_code;
    logic [2:0]            nbytes;
    logic [COUNT_BITS-1:0] remaining;
    logic [31:0]           accum_new;
    logic [7:0]            count;
    logic [7:0]            rep;
    logic                  overrun;
    logic                  last;
    logic [8:0]            raw_len;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_type_reg  <= tgapsd_pkg::IMG_RAW_COLOR;
            color_bits_reg  <= tgapsd_pkg::BPP_32;
            pixel_count_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                tgapsd_pkg::CFG_IMAGE_TYPE:  image_type_reg  <= cfg_data[7:0];
                tgapsd_pkg::CFG_COLOR_BITS:  color_bits_reg  <= cfg_data[7:0];
                tgapsd_pkg::CFG_PIXEL_COUNT: pixel_count_reg <= COUNT_BITS'(cfg_data);
                default: ;
            endcase
        end
    end

    // mode classification
    always_comb
    begin
        mode_ok   = 1'b1;
        coded     = 1'b0;
        size_code = tgapsd_pkg::SIZE_4B;
        case (image_type_reg)
            tgapsd_pkg::IMG_GREY:
            begin
                size_code = tgapsd_pkg::SIZE_1B;
            end
            tgapsd_pkg::IMG_RAW_COLOR:
            begin
                case (color_bits_reg)
                    tgapsd_pkg::BPP_16: size_code = tgapsd_pkg::SIZE_2B;
                    tgapsd_pkg::BPP_24: size_code = tgapsd_pkg::SIZE_3B;
                    tgapsd_pkg::BPP_32: size_code = tgapsd_pkg::SIZE_4B;
                    default:            mode_ok   = 1'b0;
                endcase
            end
            tgapsd_pkg::IMG_RLE_COLOR:
            begin
                coded = 1'b1;
                case (color_bits_reg)
                    tgapsd_pkg::BPP_24: size_code = tgapsd_pkg::SIZE_3B;
                    tgapsd_pkg::BPP_32: size_code = tgapsd_pkg::SIZE_4B;
                    default:            mode_ok   = 1'b0;
                endcase
            end
            default:
            begin
                mode_ok = 1'b0;
            end
        endcase
        nbytes = {1'b0, size_code} + 3'd1;
    end

    // per-byte decode and state update
    always_comb
    begin
        pd_eff    = in_item.image_start ? '0     : pixels_done_reg;
        pl_eff    = in_item.image_start ? 8'd0   : packet_left_reg;
        run_eff   = in_item.image_start ? 1'b0   : packet_is_run_reg;
        phase_eff = in_item.image_start ? 2'd0   : byte_phase_reg;
        accum_eff = in_item.image_start ? 32'd0  : colour_accum_reg;
        clip_eff  = in_item.image_start ? 1'b0   : clip_pending_reg;
        done_eff  = in_item.image_start ? 1'b0   : image_done_reg;

        pixels_done_next   = pd_eff;
        packet_left_next   = pl_eff;
        packet_is_run_next = run_eff;
        byte_phase_next    = phase_eff;
        colour_accum_next  = accum_eff;
        clip_pending_next  = clip_eff;
        image_done_next    = done_eff;

        remaining = pixel_count_reg - pd_eff;
        raw_len   = {1'b0, in_item.data_byte} + 9'd1;
        accum_new = ((phase_eff == 2'd0) ? 32'd0 : accum_eff)
                  | (32'(in_item.data_byte) << {phase_eff, 3'b000});
        count     = (coded && run_eff) ? pl_eff : 8'd1;
        overrun   = CMP_W'(count) > CMP_W'(remaining);
        rep       = overrun ? remaining[7:0] : count;
        last      = (pd_eff + COUNT_BITS'(rep)) == pixel_count_reg;

        push = 1'b0;
        job.colour_accum  = accum_new;
        job.size_code     = size_code;
        job.repeat_count  = rep;
        job.image_last    = last;
        job.overrun_error = overrun
                          || (!(coded && (count > 8'd1)) && clip_eff && last);

        if (in_accept && !done_eff)
        begin
            if (pd_eff >= pixel_count_reg)
            begin
                image_done_next = 1'b1;
            end
            else if (mode_ok)
            begin
                if (coded && (pl_eff == 8'd0))
                begin
                    // packet header
                    if (in_item.data_byte < tgapsd_pkg::RLE_RUN_FLAG)
                    begin
                        packet_left_next   = raw_len[7:0];
                        packet_is_run_next = 1'b0;
                        if (CMP_W'(raw_len) > CMP_W'(remaining))
                            clip_pending_next = 1'b1;
                    end
                    else
                    begin
                        packet_left_next   = in_item.data_byte - tgapsd_pkg::RLE_RUN_BIAS;
                        packet_is_run_next = 1'b1;
                    end
                    byte_phase_next   = 2'd0;
                    colour_accum_next = 32'd0;
                end
                else
                begin
                    colour_accum_next = accum_new;
                    if (({1'b0, phase_eff} + 3'd1) < nbytes)
                    begin
                        byte_phase_next = phase_eff + 2'd1;
                    end
                    else
                    begin
                        // pixel complete
                        byte_phase_next = 2'd0;
                        push            = 1'b1;
                        if (coded && run_eff)
                            packet_left_next = 8'd0;
                        else if (coded)
                            packet_left_next = pl_eff - 8'd1;
                        pixels_done_next = pd_eff + COUNT_BITS'(rep);
                        if (last)
                        begin
                            image_done_next   = 1'b1;
                            clip_pending_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_done_reg   <= '0;
            packet_left_reg   <= 8'd0;
            packet_is_run_reg <= 1'b0;
            byte_phase_reg    <= 2'd0;
            colour_accum_reg  <= 32'd0;
            clip_pending_reg  <= 1'b0;
            image_done_reg    <= 1'b1;
        end
        else if (in_accept)
        begin
            pixels_done_reg   <= pixels_done_next;
            packet_left_reg   <= packet_left_next;
            packet_is_run_reg <= packet_is_run_next;
            byte_phase_reg    <= byte_phase_next;
            colour_accum_reg  <= colour_accum_next;
            clip_pending_reg  <= clip_pending_next;
            image_done_reg    <= image_done_next;
        end
    end

    // a pixel never carries a zero repeat count
    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (job.repeat_count != 8'd0))
        else $error("front pushed a pixel with zero repeat count");

    // an overrun is only flagged on the item that completes the image
    a_overrun_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && job.overrun_error) |-> job.image_last)
        else $error("overrun flagged before the image end");

    // once the last pixel goes out the decoder waits for a new image
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && job.image_last) |=> image_done_reg)
        else $error("image not marked done after its last pixel");

endmodule

// File: rtl/tgapsd_queue.sv
module tgapsd_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  tgapsd_pkg::tga_job_t          push_data,
    input  logic                          pop,
    output tgapsd_pkg::tga_job_t          head_data,
    output tgapsd_pkg::tga_queue_status_t status
);

    localparam int unsigned DEPTH = tgapsd_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tgapsd_pkg::tga_job_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    assign head_data    = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from an empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// File: rtl/tgapsd_back.sv
module tgapsd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tgapsd_pkg::tga_queue_status_t status,
    input  tgapsd_pkg::tga_job_t          head_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tgapsd_pkg::tga_out_t          out_item
);

    logic                 out_valid_reg, out_valid_next;
    tgapsd_pkg::tga_out_t out_item_reg;
    logic [31:0]          argb;
    logic [31:0]          a;

    // take the next pixel when the output register is free or draining
    assign pop = !status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // pixel formatting to argb
    always_comb
    begin
        a = head_data.colour_accum;
        case (head_data.size_code)
            tgapsd_pkg::SIZE_1B:
                argb = {a[7:0], a[7:0], a[7:0], a[7:0]};
            tgapsd_pkg::SIZE_2B:
                argb = {tgapsd_pkg::ALPHA_OPAQUE,
                        a[14:10] & tgapsd_pkg::RGB555_MASK, 3'b000,
                        a[9:5]   & tgapsd_pkg::RGB555_MASK, 3'b000,
                        a[4:0]   & tgapsd_pkg::RGB555_MASK, 3'b000};
            tgapsd_pkg::SIZE_3B:
                argb = {tgapsd_pkg::ALPHA_OPAQUE, a[23:0]};
            default:
                argb = a;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg.pixel_argb    <= argb;
            out_item_reg.repeat_count  <= head_data.repeat_count;
            out_item_reg.image_last    <= head_data.image_last;
            out_item_reg.overrun_error <= head_data.overrun_error;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: rtl/tga_pixel_stream_decoder_top.sv
// TGA pixel stream decoder: takes the pixel bytes that follow a TGA header, one byte per
// item, and emits ARGB pixels with a repeat count (grey, raw 16/24/32-bit and RLE
// 24/32-bit data). While the queue is not full, the front accepts one byte every clock
// with its whole phase, packet and pixel count update done in that cycle, so the sustained
// rate is one byte per clock. Finished pixels go through a four-entry queue to the back,
// which formats ARGB into the output register; a result is written to a queue entry when
// its last byte is accepted and then to the output register. in_stall rises only while the
// queue is full, i.e. after the output side has stalled. Configuration is taken at any cycle
// with cfg_write_en high and should only change while no image is being decoded.
module tga_pixel_stream_decoder_top #(
    parameter int unsigned COUNT_BITS = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [1:0]                        cfg_index,
    input  logic [tgapsd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tgapsd_pkg::tga_in_t               in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tgapsd_pkg::tga_out_t              out_item
);

    logic                          in_accept;
    logic                          push;
    logic                          pop;
    tgapsd_pkg::tga_job_t          job;
    tgapsd_pkg::tga_job_t          head_data;
    tgapsd_pkg::tga_queue_status_t status;

    assign in_stall  = status.full;
    assign in_accept = in_valid && !status.full;

    tgapsd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (in_accept),
        .in_item      (in_item),
        .push         (push),
        .job          (job)
    );

    tgapsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job),
        .pop       (pop),
        .head_data (head_data),
        .status    (status)
    );

    tgapsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .head_data (head_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
